### sv/pan_tilt_pi_servo_tracker_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef PAN_TILT_PI_SERVO_TRACKER_MACROS_SVH
`define PAN_TILT_PI_SERVO_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define PTST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`define PTST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTST_ASSERT(label, prop, msg)
`define PTST_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### sv/ptst_pkg.sv
package ptst_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int CENTRE_W       = 10;
  localparam int GAIN_W         = 8;
  localparam int DEADBAND_W     = 10;
  localparam int TICK_W         = 8;
  localparam int PERIOD_W       = 16;
  localparam int DUTY_W         = 14;
  localparam int PULSE_W        = 16;
  localparam int INTEG_W        = 13;
  localparam int OUT_W          = 16;
  localparam int DATA_W         = 32;

  localparam int AXES      = 2;
  localparam int AXIS_TILT = 0;
  localparam int AXIS_PAN  = 1;

  localparam int DUTY_LOW  [AXES] = '{1200, 1000};
  localparam int DUTY_HIGH [AXES] = '{5000, 5000};
  localparam int DUTY_MID  [AXES] = '{3000, 3400};
  localparam int INTEG_LOW  [AXES] = '{1200 - 3000, 1000 - 3400};
  localparam int INTEG_HIGH [AXES] = '{5000 - 3000, 5000 - 3400};

  localparam int GAIN_SCALE = 100;
  localparam int DUTY_FULL  = 10000;

  localparam int PULSE_PROD_W = PERIOD_W + DUTY_W;
  localparam int PULSE_SHIFT  = PULSE_PROD_W + $clog2(DUTY_FULL);
  localparam longint unsigned PULSE_MAGIC =
    ((64'd1 << PULSE_SHIFT) + DUTY_FULL - 1) / DUTY_FULL;
  localparam int PULSE_MUL_W  = 2 * PULSE_PROD_W + 1;

  localparam logic [GAIN_W-1:0]     PROP_GAIN_RST  = 8'd50;
  localparam logic [GAIN_W-1:0]     INTEG_GAIN_RST = 8'd25;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST   = 10'd20;
  localparam logic [TICK_W-1:0]     TICK_DIV_RST   = 8'd10;
  localparam logic [PERIOD_W-1:0]   PERIOD_RST     = 16'd10000;
  localparam logic [CENTRE_W-1:0]   CENTRE_X_RST   = 10'd160;
  localparam logic [CENTRE_W-1:0]   CENTRE_Y_RST   = 10'd120;

  localparam int REG_COUNT = 7;
  localparam int ADDR_W    = $clog2(REG_COUNT) + 2;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SET_POS  = 2'd1,
    CMD_SET_PEND = 2'd2
  } cmd_t;

  typedef enum logic [ADDR_W-3:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DEADBAND   = 3'd2,
    REG_TICK_DIV   = 3'd3,
    REG_PWM_PERIOD = 3'd4,
    REG_CENTRE_X   = 3'd5,
    REG_CENTRE_Y   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                          upd;
    logic [AXES-1:0][DUTY_W-1:0]   duty;
    logic [AXES-1:0]               lim;
  } res_t;

endpackage

### sv/pan_tilt_pi_servo_tracker.sv
// Every item taken yields a result on out_valid, one beat per cycle while out_ready is high.
// The three stages are the PI state update, the period*duty product and the /10000
// reciprocal multiply that yields the pulse values.
// in_ready drops after reset and after every register write while the
// per-axis gain products reload. rst_n (synchronous) restores register reset values,
// zeroes tracker state, sets duties to their midpoints and empties the result pipe.
`include "pan_tilt_pi_servo_tracker_macros.svh"

module pan_tilt_pi_servo_tracker
  import ptst_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic                  in_pending_value,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_update_valid,
  output logic [DUTY_W-1:0]     out_tilt_duty,
  output logic [DUTY_W-1:0]     out_pan_duty,
  output logic [PULSE_W-1:0]    out_tilt_pulse,
  output logic [PULSE_W-1:0]    out_pan_pulse,
  output logic                  out_tilt_limited,
  output logic                  out_pan_limited,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam int EW = ((COORD_BITS > CENTRE_W) ? COORD_BITS : CENTRE_W) + 1;
  localparam int PW = EW + GAIN_W;
  localparam int MW = EW + GAIN_W - 1;
  localparam int QW = MW - 6;
  localparam int SW = EW + 6;
  localparam int DIV_SHIFT = MW + $clog2(GAIN_SCALE);
  localparam longint unsigned DIV_MAGIC =
    ((64'd1 << DIV_SHIFT) + GAIN_SCALE - 1) / GAIN_SCALE;

  logic [GAIN_W-1:0]     prop_gain_r;
  logic [GAIN_W-1:0]     integ_gain_r;
  logic [DEADBAND_W-1:0] deadband_r;
  logic [TICK_W-1:0]     tick_div_r;
  logic [PERIOD_W-1:0]   pwm_period_r;
  logic [CENTRE_W-1:0]   centre_r [AXES];
  logic                  cfg_wr;
  logic                  dirty_r;

  logic [TICK_W-1:0]     tick_cnt_r, tick_nxt;
  logic                  pend_r, pend_nxt;
  logic [COORD_BITS-1:0] latched_r [AXES];
  logic [COORD_BITS-1:0] latched_nxt [AXES];
  logic [COORD_BITS-1:0] pos_in [AXES];
  logic signed [INTEG_W-1:0] integ_r [AXES];
  logic signed [INTEG_W-1:0] integ_nxt [AXES];
  logic signed [INTEG_W-1:0] integ_pi [AXES];
  logic signed [OUT_W-1:0]   outv_r [AXES];
  logic signed [OUT_W-1:0]   outv_nxt [AXES];
  logic signed [OUT_W-1:0]   outv_pi [AXES];
  logic [AXES-1:0][DUTY_W-1:0] duty_r, duty_nxt, duty_pi, duty_hold;
  logic [AXES-1:0]       lim_r, lim_nxt, lim_pi, band;
  logic                  upd_nxt;

  logic                  in_fire, load_pos, tick_expire;
  logic                  a_adv, b_adv, c_adv;
  logic                  a_valid_r, b_valid_r, out_valid_r;
  res_t                  a_r, b_r, out_r;
  logic [AXES-1:0][PULSE_PROD_W-1:0] b_prod_r;
  logic [AXES-1:0][PULSE_W-1:0]      out_pulse_r, pulse_nxt;
  logic [PULSE_MUL_W-1:0]            pulse_mul [AXES];

  function automatic logic signed [QW:0] div_gain(input logic signed [PW-1:0] p);
    logic [MW-1:0]   mag;
    logic [2*MW:0]   prod;
    logic [QW-1:0]   q;
    mag  = p[PW-1] ? MW'(-p) : MW'(p);
    prod = (2*MW+1)'(mag) * (2*MW+1)'(DIV_MAGIC);
    q    = prod[DIV_SHIFT +: QW];
    div_gain = p[PW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic [DUTY_W-1:0] duty_clamp(input logic signed [OUT_W-1:0] o,
                                                   input int ax);
    logic signed [OUT_W+1:0] d;
    d = (OUT_W+2)'(o) + (OUT_W+2)'(DUTY_MID[ax]);
    if (d > (OUT_W+2)'(DUTY_HIGH[ax])) begin
      duty_clamp = DUTY_W'(DUTY_HIGH[ax]);
    end else if (d < (OUT_W+2)'(DUTY_LOW[ax])) begin
      duty_clamp = DUTY_W'(DUTY_LOW[ax]);
    end else begin
      duty_clamp = DUTY_W'(d);
    end
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r         <= PROP_GAIN_RST;
      integ_gain_r        <= INTEG_GAIN_RST;
      deadband_r          <= DEADBAND_RST;
      tick_div_r          <= TICK_DIV_RST;
      pwm_period_r        <= PERIOD_RST;
      centre_r[AXIS_PAN]  <= CENTRE_X_RST;
      centre_r[AXIS_TILT] <= CENTRE_Y_RST;
      dirty_r             <= 1'b1;
    end else begin
      dirty_r <= cfg_wr;
      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_PROP_GAIN:  prop_gain_r         <= pwdata[GAIN_W-1:0];
          REG_INTEG_GAIN: integ_gain_r        <= pwdata[GAIN_W-1:0];
          REG_DEADBAND:   deadband_r          <= pwdata[DEADBAND_W-1:0];
          REG_TICK_DIV:   tick_div_r          <= pwdata[TICK_W-1:0];
          REG_PWM_PERIOD: pwm_period_r        <= pwdata[PERIOD_W-1:0];
          REG_CENTRE_X:   centre_r[AXIS_PAN]  <= pwdata[CENTRE_W-1:0];
          REG_CENTRE_Y:   centre_r[AXIS_TILT] <= pwdata[CENTRE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[ADDR_W-1:2]))
      REG_PROP_GAIN:  prdata = DATA_W'(prop_gain_r);
      REG_INTEG_GAIN: prdata = DATA_W'(integ_gain_r);
      REG_DEADBAND:   prdata = DATA_W'(deadband_r);
      REG_TICK_DIV:   prdata = DATA_W'(tick_div_r);
      REG_PWM_PERIOD: prdata = DATA_W'(pwm_period_r);
      REG_CENTRE_X:   prdata = DATA_W'(centre_r[AXIS_PAN]);
      REG_CENTRE_Y:   prdata = DATA_W'(centre_r[AXIS_TILT]);
      default:        prdata = '0;
    endcase
  end

  // handshake and pipe advance
  assign c_adv    = !out_valid_r || out_ready;
  assign b_adv    = !b_valid_r || c_adv;
  assign a_adv    = !a_valid_r || b_adv;
  assign in_ready = a_adv && !dirty_r;
  assign in_fire  = in_valid && in_ready;
  assign load_pos = in_fire && (in_command == CMD_SET_POS);
  assign tick_expire = tick_cnt_r >= tick_div_r;

  assign pos_in[AXIS_TILT] = in_pos_y;
  assign pos_in[AXIS_PAN]  = in_pos_x;

  // per-axis gain products, kept current with the latched target
  for (genvar g = 0; g < AXES; g++) begin : g_axis
    logic [COORD_BITS-1:0] src;
    logic signed [EW-1:0]  err;
    logic signed [EW:0]    err_x, db_x;
    logic signed [PW-1:0]  prod_i_nxt, prod_p_nxt, prod_i_r, prod_p_r;
    logic                  band_nxt, band_r;
    logic signed [QW:0]    q_i, q_p;
    logic signed [SW-1:0]  isum, osum;
    logic signed [INTEG_W-1:0] integ_new;
    logic                  lim_new;

    assign src   = load_pos ? pos_in[g] : latched_r[g];
    assign err   = $signed({1'b0, (EW-1)'(src)}) - $signed({1'b0, (EW-1)'(centre_r[g])});
    assign err_x = (EW+1)'(err);
    assign db_x  = $signed((EW+1)'(deadband_r));
    assign band_nxt   = (err_x >= db_x) || (err_x <= -db_x);
    assign prod_i_nxt = PW'(err) * $signed({{(PW-GAIN_W){1'b0}}, integ_gain_r});
    assign prod_p_nxt = PW'(err) * $signed({{(PW-GAIN_W){1'b0}}, prop_gain_r});

    always_ff @(posedge clk) begin
      prod_i_r <= prod_i_nxt;
      prod_p_r <= prod_p_nxt;
      band_r   <= band_nxt;
    end

    assign q_i  = div_gain(prod_i_r);
    assign q_p  = div_gain(prod_p_r);
    assign isum = SW'(integ_r[g]) + SW'(q_i);

    always_comb begin
      lim_new = 1'b1;
      if (isum > SW'(INTEG_HIGH[g])) begin
        integ_new = INTEG_W'(INTEG_HIGH[g]);
      end else if (isum < SW'(INTEG_LOW[g])) begin
        integ_new = INTEG_W'(INTEG_LOW[g]);
      end else begin
        integ_new = INTEG_W'(isum);
        lim_new   = 1'b0;
      end
    end

    assign osum         = SW'(integ_new) + SW'(q_p);
    assign integ_pi[g]  = integ_new;
    assign outv_pi[g]   = $signed(osum[OUT_W-1:0]);
    assign lim_pi[g]    = lim_new;
    assign band[g]      = band_r;
    assign duty_pi[g]   = duty_clamp($signed(osum[OUT_W-1:0]), g);
    assign duty_hold[g] = duty_clamp(outv_r[g], g);
  end

  // tracker state update
  always_comb begin
    tick_nxt    = tick_cnt_r;
    pend_nxt    = pend_r;
    latched_nxt = latched_r;
    integ_nxt   = integ_r;
    outv_nxt    = outv_r;
    duty_nxt    = duty_r;
    lim_nxt     = lim_r;
    upd_nxt     = 1'b0;
    if (in_fire) begin
      unique case (in_command)
        CMD_TICK: begin
          if (tick_expire) begin
            tick_nxt = '0;
            upd_nxt  = 1'b1;
            if (pend_r) begin
              pend_nxt = 1'b0;
              for (int k = 0; k < AXES; k++) begin
                if (band[k]) begin
                  integ_nxt[k] = integ_pi[k];
                  outv_nxt[k]  = outv_pi[k];
                  lim_nxt[k]   = lim_pi[k];
                  duty_nxt[k]  = duty_pi[k];
                end else begin
                  duty_nxt[k]  = duty_hold[k];
                end
              end
            end
          end else begin
            tick_nxt = tick_cnt_r + TICK_W'(1);
          end
        end
        CMD_SET_POS: begin
          latched_nxt[AXIS_TILT] = in_pos_y;
          latched_nxt[AXIS_PAN]  = in_pos_x;
        end
        CMD_SET_PEND: pend_nxt = in_pending_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r <= '0;
      pend_r     <= 1'b0;
      lim_r      <= '0;
      for (int k = 0; k < AXES; k++) begin
        latched_r[k] <= '0;
        integ_r[k]   <= '0;
        outv_r[k]    <= '0;
        duty_r[k]    <= DUTY_W'(DUTY_MID[k]);
      end
    end else begin
      tick_cnt_r <= tick_nxt;
      pend_r     <= pend_nxt;
      latched_r  <= latched_nxt;
      integ_r    <= integ_nxt;
      outv_r     <= outv_nxt;
      duty_r     <= duty_nxt;
      lim_r      <= lim_nxt;
    end
  end

  // result pipe: snapshot, period*duty, /10000
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      pulse_mul[k] = PULSE_MUL_W'(b_prod_r[k]) * PULSE_MUL_W'(PULSE_MAGIC);
      pulse_nxt[k] = pulse_mul[k][PULSE_SHIFT +: PULSE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_r <= in_fire;
      end
      if (b_adv) begin
        b_valid_r <= a_valid_r;
      end
      if (c_adv) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_r.upd  <= upd_nxt;
      a_r.duty <= duty_nxt;
      a_r.lim  <= lim_nxt;
    end
    if (b_adv) begin
      b_r <= a_r;
      for (int k = 0; k < AXES; k++) begin
        b_prod_r[k] <= PULSE_PROD_W'(pwm_period_r) * PULSE_PROD_W'(a_r.duty[k]);
      end
    end
    if (c_adv) begin
      out_r       <= b_r;
      out_pulse_r <= pulse_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_update_valid = out_r.upd;
  assign out_tilt_duty    = out_r.duty[AXIS_TILT];
  assign out_pan_duty     = out_r.duty[AXIS_PAN];
  assign out_tilt_pulse   = out_pulse_r[AXIS_TILT];
  assign out_pan_pulse    = out_pulse_r[AXIS_PAN];
  assign out_tilt_limited = out_r.lim[AXIS_TILT];
  assign out_pan_limited  = out_r.lim[AXIS_PAN];

  `PTST_ASSERT_NEXT(a_cfg_reload, cfg_wr, !in_ready, "item taken while gain products reload")
  `PTST_ASSERT(a_duty_range, (duty_r[AXIS_TILT] >= DUTY_W'(DUTY_LOW[AXIS_TILT])) && (duty_r[AXIS_TILT] <= DUTY_W'(DUTY_HIGH[AXIS_TILT])) && (duty_r[AXIS_PAN] >= DUTY_W'(DUTY_LOW[AXIS_PAN])) && (duty_r[AXIS_PAN] <= DUTY_W'(DUTY_HIGH[AXIS_PAN])), "duty outside axis limits")
  `PTST_ASSERT(a_integ_range, (integ_r[AXIS_TILT] >= INTEG_W'(INTEG_LOW[AXIS_TILT])) && (integ_r[AXIS_TILT] <= INTEG_W'(INTEG_HIGH[AXIS_TILT])) && (integ_r[AXIS_PAN] >= INTEG_W'(INTEG_LOW[AXIS_PAN])) && (integ_r[AXIS_PAN] <= INTEG_W'(INTEG_HIGH[AXIS_PAN])), "integral outside clamp")
  `PTST_ASSERT_NEXT(a_tick_restart, in_fire && (in_command == CMD_TICK) && tick_expire, tick_cnt_r == '0, "prescaler did not restart on expiry")

endmodule

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ptst_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 160;
  localparam int CW           = COORD_BITS_DEF;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  typedef struct {
    logic               upd;
    logic [DUTY_W-1:0]  tilt_duty;
    logic [DUTY_W-1:0]  pan_duty;
    logic [PULSE_W-1:0] tilt_pulse;
    logic [PULSE_W-1:0] pan_pulse;
    logic               tilt_lim;
    logic               pan_lim;
  } servo_update_t;

  class tracker_predictor;
    bit [GAIN_W-1:0]     prop_gain, integ_gain;
    bit [DEADBAND_W-1:0] deadband;
    bit [TICK_W-1:0]     tick_divide, tick_count;
    bit [PERIOD_W-1:0]   pwm_period;
    bit [CENTRE_W-1:0]   centre_x, centre_y;
    bit                  frame_pending;
    bit [CW-1:0]         lat_x, lat_y;
    int                  integ [AXES];
    int                  drive [AXES];
    int                  duty [AXES];
    bit                  limited [AXES];
    servo_update_t       due [$];
    int                  errors, results, refreshes, pi_steps, clamps;

    function new();
      prop_gain   = PROP_GAIN_RST;
      integ_gain  = INTEG_GAIN_RST;
      deadband    = DEADBAND_RST;
      tick_divide = TICK_DIV_RST;
      pwm_period  = PERIOD_RST;
      centre_x    = CENTRE_X_RST;
      centre_y    = CENTRE_Y_RST;
      foreach (duty[a]) begin
        integ[a]   = 0;
        drive[a]   = 0;
        duty[a]    = DUTY_MID[a];
        limited[a] = 0;
      end
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
      case (idx)
        REG_PROP_GAIN:  prop_gain = v[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain = v[GAIN_W-1:0];
        REG_DEADBAND:   deadband = v[DEADBAND_W-1:0];
        REG_TICK_DIV:   tick_divide = v[TICK_W-1:0];
        REG_PWM_PERIOD: pwm_period = v[PERIOD_W-1:0];
        REG_CENTRE_X:   centre_x = v[CENTRE_W-1:0];
        REG_CENTRE_Y:   centre_y = v[CENTRE_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [PULSE_W-1:0] pulse(int d);
      longint unsigned p;
      p = longint'(pwm_period) * longint'(d) / DUTY_FULL;
      return p[PULSE_W-1:0];
    endfunction

    function void pi_step(int ax, int err);
      int acc;
      int sum;
      logic [OUT_W-1:0] w;
      acc = integ[ax] + int'(integ_gain) * err / GAIN_SCALE;
      limited[ax] = 0;
      if (acc > INTEG_HIGH[ax]) begin
        acc = INTEG_HIGH[ax];
        limited[ax] = 1;
      end else if (acc < INTEG_LOW[ax]) begin
        acc = INTEG_LOW[ax];
        limited[ax] = 1;
      end
      integ[ax] = acc;
      sum = int'(prop_gain) * err / GAIN_SCALE + acc;
      w = sum[OUT_W-1:0];
      drive[ax] = $signed(w);
      pi_steps++;
      if (limited[ax]) clamps++;
    endfunction

    function void take_command(logic [1:0] cmd, logic [CW-1:0] x, logic [CW-1:0] y, logic pv);
      servo_update_t r;
      int err [AXES];
      int d;
      r.upd = 0;
      if (cmd == CMD_SET_POS) begin
        lat_x = x;
        lat_y = y;
      end else if (cmd == CMD_SET_PEND) begin
        frame_pending = pv;
      end else if (cmd == CMD_TICK) begin
        if (tick_count >= tick_divide) begin
          tick_count = 0;
          r.upd = 1;
          refreshes++;
          if (frame_pending) begin
            frame_pending = 0;
            err[AXIS_TILT] = int'(lat_y) - int'(centre_y);
            err[AXIS_PAN]  = int'(lat_x) - int'(centre_x);
            for (int a = 0; a < AXES; a++) begin
              if (err[a] >= int'(deadband) || err[a] <= -int'(deadband)) pi_step(a, err[a]);
              d = drive[a] + DUTY_MID[a];
              if (d > DUTY_HIGH[a]) d = DUTY_HIGH[a];
              else if (d < DUTY_LOW[a]) d = DUTY_LOW[a];
              duty[a] = d;
            end
          end
        end else begin
          tick_count++;
        end
      end
      r.tilt_duty  = DUTY_W'(duty[AXIS_TILT]);
      r.pan_duty   = DUTY_W'(duty[AXIS_PAN]);
      r.tilt_pulse = pulse(duty[AXIS_TILT]);
      r.pan_pulse  = pulse(duty[AXIS_PAN]);
      r.tilt_lim   = limited[AXIS_TILT];
      r.pan_lim    = limited[AXIS_PAN];
      due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("testbench: mismatch at %0t: %s", $time, msg);
    endtask

    task compare_update(servo_update_t got);
      servo_update_t want;
      results++;
      if (due.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      want = due.pop_front();
      if (got.upd !== want.upd)
        report($sformatf("update_valid %0d, want %0d", got.upd, want.upd));
      if (got.tilt_duty !== want.tilt_duty)
        report($sformatf("tilt_duty %0d, want %0d", got.tilt_duty, want.tilt_duty));
      if (got.pan_duty !== want.pan_duty)
        report($sformatf("pan_duty %0d, want %0d", got.pan_duty, want.pan_duty));
      if (got.tilt_pulse !== want.tilt_pulse)
        report($sformatf("tilt_pulse %0d, want %0d", got.tilt_pulse, want.tilt_pulse));
      if (got.pan_pulse !== want.pan_pulse)
        report($sformatf("pan_pulse %0d, want %0d", got.pan_pulse, want.pan_pulse));
      if (got.tilt_lim !== want.tilt_lim)
        report($sformatf("tilt_limited %0d, want %0d", got.tilt_lim, want.tilt_lim));
      if (got.pan_lim !== want.pan_lim)
        report($sformatf("pan_limited %0d, want %0d", got.pan_lim, want.pan_lim));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;

  logic              in_valid = 0;
  logic              in_ready;
  logic [1:0]        in_command = CMD_TICK;
  logic [CW-1:0]     in_pos_x = '0;
  logic [CW-1:0]     in_pos_y = '0;
  logic              in_pending_value = 0;

  logic              out_valid;
  logic              out_ready = 0;
  logic              out_update_valid;
  logic [DUTY_W-1:0] out_tilt_duty, out_pan_duty;
  logic [PULSE_W-1:0] out_tilt_pulse, out_pan_pulse;
  logic              out_tilt_limited, out_pan_limited;

  logic              psel = 0;
  logic              penable = 0;
  logic              pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tracker_predictor pred;
  int send_idle = 13;
  int recv_idle = 67;
  int stall_cycles = 0;
  int items_sent = 0;
  int settings = 0;

  pan_tilt_pi_servo_tracker uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pending_value (in_pending_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_update_valid (out_update_valid),
    .out_tilt_duty    (out_tilt_duty),
    .out_pan_duty     (out_pan_duty),
    .out_tilt_pulse   (out_tilt_pulse),
    .out_pan_pulse    (out_pan_pulse),
    .out_tilt_limited (out_tilt_limited),
    .out_pan_limited  (out_pan_limited),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    servo_update_t got;
    if (rst_n && in_valid && in_ready)
      pred.take_command(in_command, in_pos_x, in_pos_y, in_pending_value);
    if (rst_n && out_valid && out_ready) begin
      got.upd        = out_update_valid;
      got.tilt_duty  = out_tilt_duty;
      got.pan_duty   = out_pan_duty;
      got.tilt_pulse = out_tilt_pulse;
      got.pan_pulse  = out_pan_pulse;
      got.tilt_lim   = out_tilt_limited;
      got.pan_lim    = out_pan_limited;
      pred.compare_update(got);
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("testbench: no beat for %0d cycles", STALL_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [CW-1:0] rcoord();
    return CW'($urandom);
  endfunction

  function automatic logic [CW-1:0] near(logic [CW-1:0] c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > (1 << CW) - 1) v = (1 << CW) - 1;
    return CW'(v);
  endfunction

  task automatic send(logic [1:0] cmd, logic [CW-1:0] x, logic [CW-1:0] y, logic pv);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid         <= 1;
    in_command       <= cmd;
    in_pos_x         <= x;
    in_pos_y         <= y;
    in_pending_value <= pv;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // hold the sender until every outstanding result is back
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pred.due.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] junk;
    logic [DATA_W-1:0] word;
    junk = $urandom;
    word = {junk[DATA_W-1:PERIOD_W], v[PERIOD_W-1:0]};
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel    <= 0;
    penable <= 0;
    pred.set_reg(idx, word);
  endtask

  task automatic set_all(int pg, int ig, int db, int td, int pp, int cx, int cy);
    apb_write(REG_PROP_GAIN, pg);
    apb_write(REG_INTEG_GAIN, ig);
    apb_write(REG_DEADBAND, db);
    apb_write(REG_TICK_DIV, td);
    apb_write(REG_PWM_PERIOD, pp);
    apb_write(REG_CENTRE_X, cx);
    apb_write(REG_CENTRE_Y, cy);
    settings++;
  endtask

  initial begin
    int n;
    int ticks;
    int spread;
    bit paused;
    logic [1:0] c;

    pred = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1;

    // reset settings: ignored code, plain tick, raise the frame flag
    send(CMD_IGNORED, rcoord(), rcoord(), 1'($urandom));
    send(CMD_TICK, rcoord(), rcoord(), 1'($urandom));
    send(CMD_SET_PEND, rcoord(), rcoord(), 1);
    settle();

    // counter already above the new divide; far corner drives both integrals high
    apb_write(REG_TICK_DIV, 0);
    apb_write(REG_INTEG_GAIN, 255);
    send(CMD_SET_POS, 1023, 1023, 1'($urandom));
    send(CMD_SET_PEND, rcoord(), rcoord(), 1);
    send(CMD_TICK, rcoord(), rcoord(), 1'($urandom));
    send(CMD_TICK, rcoord(), rcoord(), 1'($urandom));
    send(CMD_SET_POS, 179, 139, 1'($urandom));
    send(CMD_SET_PEND, rcoord(), rcoord(), 1);
    send(CMD_TICK, rcoord(), rcoord(), 1'($urandom));
    send(CMD_SET_POS, 140, 100, 1'($urandom));
    send(CMD_SET_PEND, rcoord(), rcoord(), 1);
    send(CMD_TICK, rcoord(), rcoord(), 1'($urandom));
    send(CMD_SET_PEND, rcoord(), rcoord(), 0);
    send(CMD_TICK, rcoord(), rcoord(), 1'($urandom));
    settle();

    set_all(255, 255, 0, 0, 65535, 1023, 1023);
    send(CMD_SET_POS, 0, 0, 1'($urandom));
    send(CMD_SET_PEND, rcoord(), rcoord(), 1);
    send(CMD_TICK, rcoord(), rcoord(), 1'($urandom));
    send(CMD_SET_POS, 1023, 1023, 1'($urandom));
    send(CMD_SET_PEND, rcoord(), rcoord(), 1);
    send(CMD_TICK, rcoord(), rcoord(), 1'($urandom));
    settle();

    set_all(0, 0, 1023, 1, 0, 0, 0);
    send(CMD_SET_POS, 1023, 1023, 1'($urandom));
    send(CMD_SET_PEND, rcoord(), rcoord(), 1);
    send(CMD_TICK, rcoord(), rcoord(), 1'($urandom));
    send(CMD_TICK, rcoord(), rcoord(), 1'($urandom));

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase < 4) begin
        send_idle = 13;
        recv_idle = 67;
      end else if (phase < 8) begin
        send_idle = 67;
        recv_idle = 13;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (phase)
        0: set_all(0, 0, 0, 0, 0, 0, 0);
        1: set_all(255, 255, 1023, 255, 65535, 1023, 1023);
        default: set_all($urandom_range(0, 255), $urandom_range(0, 255),
                         ($urandom_range(3) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 40),
                         $urandom_range(0, 6), $urandom_range(0, 65535),
                         $urandom_range(0, 1023), $urandom_range(0, 1023));
      endcase
      n = 0;
      paused = 0;
      while (n < PHASE_ITEMS) begin
        if (phase == 5 && !paused && n >= PHASE_ITEMS / 2) begin
          settle();
          paused = 1;
        end
        if ($urandom_range(99) < 80) begin
          spread = ($urandom_range(1) == 0) ? int'(pred.deadband) + 8 : 1023;
          send(CMD_SET_POS, near(pred.centre_x, spread), near(pred.centre_y, spread),
               1'($urandom));
          send(CMD_SET_PEND, rcoord(), rcoord(), ($urandom_range(9) != 0));
          ticks = $urandom_range(1, (pred.tick_divide > 12) ? 14 : pred.tick_divide + 2);
          for (int t = 0; t < ticks; t++) send(CMD_TICK, rcoord(), rcoord(), 1'($urandom));
          n += 2 + ticks;
        end else begin
          c = 2'($urandom_range(0, 3));
          send(c, rcoord(), rcoord(), 1'($urandom));
          if (c != CMD_IGNORED) n++;
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("testbench: %0d commands over %0d register settings, %0d results, %0d refreshes",
             items_sent, settings, pred.results, pred.refreshes);
    $display("testbench: %0d PI steps, %0d integral clamps, %0d mismatches",
             pred.pi_steps, pred.clamps, pred.errors);
    if (pred.errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/ptst_pkg.sv
sv/pan_tilt_pi_servo_tracker.sv
verif/testbench.sv
